// ----- sv/ssrf_pkg.sv -----
package ssrf_pkg;

   // Bitmap geometry. PORT_SPACE may be any power of two from 256 up to 65536.
   localparam int PORT_SPACE = 65536;
   localparam int ROW_BITS = 64;
   localparam int ROW_SEL_W = $clog2(ROW_BITS);
   localparam int SLOT_W = $clog2(PORT_SPACE);
   localparam int ROW_COUNT = PORT_SPACE / ROW_BITS;
   localparam int ROW_ADDR_W = SLOT_W - ROW_SEL_W;

   // Frame layout.
   localparam int MIN_FRAME_BYTES = 51;
   localparam int POS_W = $clog2(MIN_FRAME_BYTES + 1);
   localparam int POS_ETYPE_HI = 12;
   localparam int POS_ETYPE_LO = 13;
   localparam int POS_IHL = 14;
   localparam int POS_PROTO = 23;
   localparam int POS_SRC_IP = 26;
   localparam int POS_DST_IP = 30;
   localparam int POS_PORT_HI = 34;
   localparam int POS_PORT_LO = 35;
   localparam int POS_FLAGS = 47;

   localparam logic [7:0] ETYPE_HI_VALUE = 8'h08;
   localparam logic [7:0] ETYPE_LO_VALUE = 8'h00;
   localparam logic [7:0] IHL_VALUE = 8'h45;
   localparam logic [7:0] PROTO_TCP = 8'h06;
   localparam int TCP_SYN_BIT = 1;
   localparam int TCP_ACK_BIT = 4;

   localparam int PORT_W = 16;
   localparam int COUNT_W = 16;
   localparam int ADDR_W = 32;
   localparam int MS_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET  = 2'd0,
      CSR_OWN     = 2'd1,
      CSR_PROBES  = 2'd2,
      CSR_TIMEOUT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      VERDICT_NONE      = 3'd0,
      VERDICT_DUPLICATE = 3'd1,
      VERDICT_CLOSED    = 3'd2,
      VERDICT_OPEN      = 3'd3,
      VERDICT_TIMEOUT   = 3'd4
   } verdict_type;

   typedef struct packed {
      logic                  frame_end;
      logic                  reply_ok;
      logic [PORT_W-1:0]     port;
      logic [7:0]            flags;
      logic                  fetch;
      logic [ROW_ADDR_W-1:0] fetch_row;
   } frame_info_type;

   typedef struct packed {
      verdict_type        verdict;
      logic [PORT_W-1:0]  reply_port;
      logic [COUNT_W-1:0] remaining;
      logic               scan_done;
   } result_type;

endpackage

// ----- sv/ssrf_ram.sv -----
module ssrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ssrf_parser.sv -----
module ssrf_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           byte_accept,
   input  logic [7:0]                     frame_byte,
   input  logic                           frame_last,
   input  logic [ssrf_pkg::ADDR_W-1:0]    target_address,
   input  logic [ssrf_pkg::ADDR_W-1:0]    own_address,
   output ssrf_pkg::frame_info_type       info
);
   import ssrf_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              match_ff, match_in;
   logic [PORT_W-1:0] port_ff, port_in;
   logic [7:0]        flags_ff, flags_in;

   logic              check;
   logic [7:0]        expect_byte;
   logic              match_now;
   logic [PORT_W-1:0] port_now;
   logic [7:0]        flags_now;
   logic [SLOT_W-1:0] slot_now;

   always_comb begin
      check = 1'b1;
      expect_byte = 8'h00;
      port_now = port_ff;
      flags_now = flags_ff;
      case (pos_ff)
         POS_W'(POS_ETYPE_HI):   expect_byte = ETYPE_HI_VALUE;
         POS_W'(POS_ETYPE_LO):   expect_byte = ETYPE_LO_VALUE;
         POS_W'(POS_IHL):        expect_byte = IHL_VALUE;
         POS_W'(POS_PROTO):      expect_byte = PROTO_TCP;
         POS_W'(POS_SRC_IP):     expect_byte = target_address[31:24];
         POS_W'(POS_SRC_IP + 1): expect_byte = target_address[23:16];
         POS_W'(POS_SRC_IP + 2): expect_byte = target_address[15:8];
         POS_W'(POS_SRC_IP + 3): expect_byte = target_address[7:0];
         POS_W'(POS_DST_IP):     expect_byte = own_address[31:24];
         POS_W'(POS_DST_IP + 1): expect_byte = own_address[23:16];
         POS_W'(POS_DST_IP + 2): expect_byte = own_address[15:8];
         POS_W'(POS_DST_IP + 3): expect_byte = own_address[7:0];
         POS_W'(POS_PORT_HI): begin
            check = 1'b0;
            port_now = {frame_byte, port_ff[7:0]};
         end
         POS_W'(POS_PORT_LO): begin
            check = 1'b0;
            port_now = {port_ff[15:8], frame_byte};
         end
         POS_W'(POS_FLAGS): begin
            check = 1'b0;
            flags_now = frame_byte;
         end
         default: check = 1'b0;
      endcase

      match_now = match_ff && !(check && (expect_byte != frame_byte));
      slot_now = port_now[SLOT_W-1:0];

      info.frame_end = byte_accept && frame_last;
      info.reply_ok = match_now && (pos_ff >= POS_W'(MIN_FRAME_BYTES - 1));
      info.port = port_now;
      info.flags = flags_now;
      // Once the low port byte is in, the bitmap row is fetched ahead of the frame end.
      info.fetch = byte_accept && (pos_ff == POS_W'(POS_PORT_LO));
      info.fetch_row = slot_now[SLOT_W-1:ROW_SEL_W];

      pos_in = pos_ff;
      match_in = match_ff;
      port_in = port_ff;
      flags_in = flags_ff;
      if (byte_accept) begin
         if (frame_last) begin
            pos_in = '0;
            match_in = 1'b1;
            port_in = '0;
            flags_in = '0;
         end else begin
            if (pos_ff < POS_W'(MIN_FRAME_BYTES)) begin
               pos_in = pos_ff + 1'b1;
            end
            match_in = match_now;
            port_in = port_now;
            flags_in = flags_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         match_ff <= 1'b1;
         port_ff <= '0;
         flags_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         match_ff <= match_in;
         port_ff <= port_in;
         flags_ff <= flags_in;
      end
   end

endmodule

// ----- sv/ssrf_scan.sv -----
module ssrf_scan (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_accept,
   input  ssrf_pkg::op_type               op,
   input  ssrf_pkg::frame_info_type       info,
   input  logic [ssrf_pkg::COUNT_W-1:0]   probe_count,
   input  logic [ssrf_pkg::MS_W-1:0]      timeout_ms,
   output logic                           clearing,
   output logic                           result_valid,
   output ssrf_pkg::result_type           result
);
   import ssrf_pkg::*;

   logic [COUNT_W-1:0]    outstanding_ff, outstanding_in;
   logic [MS_W-1:0]       elapsed_ff, elapsed_in;
   logic                  finished_ff, finished_in;
   logic                  clear_ff, clear_in;
   logic [ROW_ADDR_W-1:0] clear_row_ff, clear_row_in;
   logic                  fetch_pend_ff, fetch_pend_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;

   logic                  wr_en;
   logic [ROW_ADDR_W-1:0] wr_addr;
   logic [ROW_BITS-1:0]   wr_data;
   logic [ROW_BITS-1:0]   rd_data;

   logic [SLOT_W-1:0]     slot;
   logic [ROW_SEL_W-1:0]  bit_sel;
   logic [ROW_BITS-1:0]   bit_mask;
   logic [COUNT_W-1:0]    outstanding_dec;
   logic [MS_W-1:0]       elapsed_inc;

   ssrf_ram #(
      .WIDTH(ROW_BITS),
      .DEPTH(ROW_COUNT)
   ) u_seen_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(info.fetch_row),
      .rd_data(rd_data)
   );

   always_comb begin
      slot = info.port[SLOT_W-1:0];
      bit_sel = slot[ROW_SEL_W-1:0];
      bit_mask = ROW_BITS'(1) << bit_sel;
      outstanding_dec = outstanding_ff - COUNT_W'(outstanding_ff != '0);
      elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;

      outstanding_in = outstanding_ff;
      elapsed_in = elapsed_ff;
      finished_in = finished_ff;
      clear_in = clear_ff;
      clear_row_in = clear_row_ff;
      fetch_pend_in = info.fetch;
      row_in = fetch_pend_ff ? rd_data : row_ff;

      wr_en = 1'b0;
      wr_addr = slot[SLOT_W-1:ROW_SEL_W];
      wr_data = row_ff | bit_mask;

      result_valid = 1'b0;
      result.verdict = VERDICT_NONE;
      result.reply_port = info.port;
      result.remaining = outstanding_ff;
      result.scan_done = finished_ff;

      // The bitmap is wiped one row per cycle; no transaction is taken meanwhile.
      if (clear_ff) begin
         wr_en = 1'b1;
         wr_addr = clear_row_ff;
         wr_data = '0;
         clear_row_in = clear_row_ff + 1'b1;
         if (clear_row_ff == ROW_ADDR_W'(ROW_COUNT - 1)) begin
            clear_in = 1'b0;
         end
      end

      if (item_accept) begin
         case (op)
            OP_START: begin
               elapsed_in = '0;
               outstanding_in = probe_count;
               finished_in = (probe_count == '0);
               clear_in = 1'b1;
               clear_row_in = '0;
               // The cleared bitmap reads as zero, so a fetched row is simply dropped.
               fetch_pend_in = 1'b0;
               row_in = '0;
            end
            OP_BYTE: begin
               if (info.frame_end) begin
                  result_valid = 1'b1;
                  if (info.reply_ok && !finished_ff) begin
                     if (row_ff[bit_sel]) begin
                        result.verdict = VERDICT_DUPLICATE;
                     end else begin
                        wr_en = 1'b1;
                        result.verdict = (info.flags[TCP_SYN_BIT] && info.flags[TCP_ACK_BIT])
                                         ? VERDICT_OPEN : VERDICT_CLOSED;
                        outstanding_in = outstanding_dec;
                        finished_in = (outstanding_dec == '0);
                        result.remaining = outstanding_dec;
                        result.scan_done = (outstanding_dec == '0);
                     end
                  end
               end
            end
            OP_TICK: begin
               elapsed_in = elapsed_inc;
               if (!finished_ff && (elapsed_inc > timeout_ms)) begin
                  finished_in = 1'b1;
                  result_valid = 1'b1;
                  result.verdict = VERDICT_TIMEOUT;
                  result.reply_port = '0;
                  result.scan_done = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         elapsed_ff <= '0;
         finished_ff <= 1'b1;
         clear_ff <= 1'b1;
         clear_row_ff <= '0;
         fetch_pend_ff <= 1'b0;
         row_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
         elapsed_ff <= elapsed_in;
         finished_ff <= finished_in;
         clear_ff <= clear_in;
         clear_row_ff <= clear_row_in;
         fetch_pend_ff <= fetch_pend_in;
         row_ff <= row_in;
      end
   end

   assign clearing = clear_ff;

endmodule

// ----- sv/ssrf_out_fifo.sv -----
module ssrf_out_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ssrf_pkg::result_type  push_data,
   output logic                  has_room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ssrf_pkg::result_type  out_data
);
   import ssrf_pkg::*;

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   always_comb begin
      pop = out_valid && out_ready;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign has_room = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data = entry_ff[rd_ptr_ff];

endmodule

// ----- sv/syn_scan_reply_filter_top.sv -----
// A result is registered in the result buffer before it is presented on rsp_.
// Throughput: one transaction per cycle while req_tready is high; the seen-port row is fetched
// from the bitmap RAM at the low port byte, so the frame end does its read-modify-write without a RAM wait.
// A two-entry result buffer keeps req_tready high until two results wait downstream.
// Reset and every start command wipe the bitmap RAM one row per cycle, all ROW_COUNT rows
// (1024 at 65536 ports); req_tready stays low meanwhile, csr_ writes are still taken.
module syn_scan_reply_filter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ssrf_pkg::REQ_DATA_W-1:0]     req_tdata,  // [7:0] frame_byte
   input  logic [1:0]                          req_tuser,  // [1:0] op
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] reply_port, [31:16] remaining, [32] scan_done, [39:33] zero
   output logic [ssrf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [2:0]                          rsp_tuser,  // [2:0] verdict
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ssrf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ssrf_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ssrf_pkg::*;

   logic [ADDR_W-1:0]  target_ff;
   logic [ADDR_W-1:0]  own_ff;
   logic [COUNT_W-1:0] probes_ff;
   logic [MS_W-1:0]    timeout_ff;

   logic               accept;
   op_type             op;
   frame_info_type     info;
   logic               clearing;
   logic               has_room;
   logic               result_valid;
   result_type         result;
   result_type         rsp_result;

   assign csr_ready = 1'b1;
   assign op = op_type'(req_tuser);
   assign req_tready = !clearing && has_room;
   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         own_ff <= '0;
         probes_ff <= '0;
         timeout_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_TARGET:  target_ff <= csr_data;
            CSR_OWN:     own_ff <= csr_data;
            CSR_PROBES:  probes_ff <= csr_data[COUNT_W-1:0];
            CSR_TIMEOUT: timeout_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ssrf_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .byte_accept   (accept && (op == OP_BYTE)),
      .frame_byte    (req_tdata),
      .frame_last    (req_tlast),
      .target_address(target_ff),
      .own_address   (own_ff),
      .info          (info)
   );

   ssrf_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .item_accept (accept),
      .op          (op),
      .info        (info),
      .probe_count (probes_ff),
      .timeout_ms  (timeout_ff),
      .clearing    (clearing),
      .result_valid(result_valid),
      .result      (result)
   );

   ssrf_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (result_valid),
      .push_data(result),
      .has_room (has_room),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (rsp_result)
   );

   assign rsp_tuser = rsp_result.verdict;
   assign rsp_tdata = {7'b0, rsp_result.scan_done, rsp_result.remaining,
                       rsp_result.reply_port};

endmodule
